>>> src/tbh_pkg.sv
package tbh_pkg;

  localparam int COUNT_W = 24;
  localparam int STAMP_W = 27;
  localparam int K_W     = 7;
  localparam int OUT_IDX_W = 14;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Input modes.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_BASE_TIME = 1'b0;
  localparam logic REG_TOP_K     = 1'b1;

  localparam logic [STAMP_W-1:0] BASE_TIME_RESET = 27'd16454916;
  localparam logic [K_W-1:0]     TOP_K_RESET     = 7'd10;

  // One hour is 36 units: the difference is shifted right by two, then
  // divided by 9 as a multiply by ceil(2^28 / 9) and a shift by 28. The
  // rounding error stays below one for every 25-bit quotient input.
  localparam int QUOT_IN_W   = STAMP_W - 2;
  localparam int RECIP_SHIFT = 28;
  localparam int PROD_W      = 2 * QUOT_IN_W;
  localparam int BIN_W       = PROD_W - RECIP_SHIFT;
  localparam logic [QUOT_IN_W-1:0] RECIP_9 = 25'd29826162;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_ADD_MUL,
    S_ADD_RD,
    S_ADD_WR,
    S_REP_SCAN,
    S_REP_DRAIN,
    S_REP_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } chain_ctrl_t;

endpackage

>>> src/tbh_cell.sv
module tbh_cell import tbh_pkg::*; #(
  parameter int IDX_W = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  chain_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]   new_idx,
  input  logic [COUNT_W-1:0] new_cnt,
  input  logic               prev_ahead,
  input  logic               prev_valid,
  input  logic [IDX_W-1:0]   prev_idx,
  input  logic [COUNT_W-1:0] prev_cnt,
  input  logic               next_valid,
  input  logic [IDX_W-1:0]   next_idx,
  input  logic [COUNT_W-1:0] next_cnt,
  output logic               ahead,
  output logic               valid,
  output logic [IDX_W-1:0]   idx,
  output logic [COUNT_W-1:0] cnt
);

  logic take_new;
  logic take_prev;

  // Bins arrive in rising index order, so an equal count from the new bin
  // ranks ahead of what this cell holds.
  assign ahead     = !valid || (new_cnt >= cnt);
  assign take_new  = ctrl.insert && ahead && !prev_ahead;
  assign take_prev = ctrl.insert && ahead && prev_ahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (take_new) begin
      valid <= 1'b1;
    end else if (take_prev) begin
      valid <= prev_valid;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      idx <= new_idx;
      cnt <= new_cnt;
    end else if (take_prev) begin
      idx <= prev_idx;
      cnt <= prev_cnt;
    end else if (ctrl.shift) begin
      idx <= next_idx;
      cnt <= next_cnt;
    end
  end

endmodule

>>> src/tbh_chain.sv
module tbh_chain import tbh_pkg::*; #(
  parameter int N_CELLS = 64,
  parameter int IDX_W   = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  chain_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]   new_idx,
  input  logic [COUNT_W-1:0] new_cnt,
  output logic [IDX_W-1:0]   head_idx,
  output logic [COUNT_W-1:0] head_cnt
);

  logic               c_ahead [N_CELLS];
  logic               c_valid [N_CELLS];
  logic [IDX_W-1:0]   c_idx   [N_CELLS];
  logic [COUNT_W-1:0] c_cnt   [N_CELLS];

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    logic               p_ahead;
    logic               p_valid;
    logic [IDX_W-1:0]   p_idx;
    logic [COUNT_W-1:0] p_cnt;
    logic               n_valid;
    logic [IDX_W-1:0]   n_idx;
    logic [COUNT_W-1:0] n_cnt;

    if (i == 0) begin : g_first
      assign p_ahead = 1'b0;
      assign p_valid = 1'b0;
      assign p_idx   = '0;
      assign p_cnt   = '0;
    end else begin : g_mid
      assign p_ahead = c_ahead[i-1];
      assign p_valid = c_valid[i-1];
      assign p_idx   = c_idx[i-1];
      assign p_cnt   = c_cnt[i-1];
    end

    if (i == N_CELLS - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_idx   = '0;
      assign n_cnt   = '0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
      assign n_idx   = c_idx[i+1];
      assign n_cnt   = c_cnt[i+1];
    end

    tbh_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_idx   (new_idx),
      .new_cnt   (new_cnt),
      .prev_ahead(p_ahead),
      .prev_valid(p_valid),
      .prev_idx  (p_idx),
      .prev_cnt  (p_cnt),
      .next_valid(n_valid),
      .next_idx  (n_idx),
      .next_cnt  (n_cnt),
      .ahead     (c_ahead[i]),
      .valid     (c_valid[i]),
      .idx       (c_idx[i]),
      .cnt       (c_cnt[i])
    );
  end

  assign head_idx = c_idx[0];
  assign head_cnt = c_cnt[0];

endmodule

>>> src/time_bin_histogram_top_k.sv
// Hour-bin histogram with top-k report. Mode 0 adds a timestamp: the bin is
// (stamp - base_time) / 36 and its count goes up by one, saturating; stamps
// before base_time or past the last bin are dropped. An add steps through
// subtract, reciprocal multiply, read and write on the count memory, and
// ends after the multiply when its stamp is dropped. Mode 1 walks all
// NUM_BINS counts through a row of MAX_K sorting cells, one bin per cycle,
// and then hands out the top_k results from the head of the row, one result
// per output transaction, the last one flagged. Ties in count go to the
// larger bin index; top_k of zero acts as one and is capped at MAX_K and
// NUM_BINS. Mode 2 holds the block while it clears every count, and a
// clearing pass also runs after reset before the first item is taken.
// Mode 3 is taken and does nothing. Configuration writes are always
// accepted and must only be made while idle.
module time_bin_histogram_top_k import tbh_pkg::*; #(
  parameter int NUM_BINS = 16384,
  parameter int MAX_K    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [STAMP_W-1:0]   stamp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] bin_index,
  output logic [COUNT_W-1:0]   hit_count,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [STAMP_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int K_CAP = (MAX_K < NUM_BINS) ? MAX_K : NUM_BINS;

  state_t state;
  state_t state_next;

  logic [STAMP_W-1:0]   base_time;
  logic [K_W-1:0]       top_k;
  logic [K_W-1:0]       k_eff;
  logic [K_W-1:0]       out_left;

  logic [QUOT_IN_W-1:0] quot_in;
  logic                 add_ok;
  logic [PROD_W-1:0]    prod;
  logic [BIN_W-1:0]     bin_full;
  logic                 bin_ok;
  logic [IDX_W-1:0]     bin_addr;

  logic [IDX_W-1:0]     walk_addr;
  logic                 walk_last;
  logic                 pipe_valid;
  logic [IDX_W-1:0]     pipe_idx;

  logic [COUNT_W-1:0]   mem [NUM_BINS];
  logic [COUNT_W-1:0]   rd_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [COUNT_W-1:0]   wr_data;
  logic                 mem_we;

  logic                 in_take;
  logic [STAMP_W-1:0]   diff;
  chain_ctrl_t          ctrl;
  logic [IDX_W-1:0]     head_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time <= BASE_TIME_RESET;
      top_k     <= TOP_K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BASE_TIME) begin
        base_time <= cfg_data;
      end else if (cfg_index == REG_TOP_K) begin
        top_k <= cfg_data[K_W-1:0];
      end
    end
  end

  always_comb begin
    k_eff = top_k;
    if (top_k == '0) begin
      k_eff = 7'd1;
    end else if (top_k > K_W'(K_CAP)) begin
      k_eff = K_W'(K_CAP);
    end
  end

  assign in_take  = in_valid && !in_stall;
  assign diff     = stamp - base_time;
  assign prod     = PROD_W'(quot_in) * PROD_W'(RECIP_9);
  assign bin_full = prod[PROD_W-1:RECIP_SHIFT];
  assign bin_ok   = add_ok && (bin_full < BIN_W'(NUM_BINS));
  assign walk_last = (walk_addr == IDX_W'(NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_take) begin
      quot_in <= diff[STAMP_W-1:2];
      add_ok  <= (stamp >= base_time);
    end
    if (state == S_ADD_MUL) begin
      bin_addr <= bin_full[IDX_W-1:0];
    end
    pipe_idx <= walk_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_addr  <= '0;
      pipe_valid <= 1'b0;
      out_left   <= '0;
    end else begin
      pipe_valid <= (state == S_REP_SCAN);
      if (state == S_REP_SCAN || state == S_WIPE) begin
        walk_addr <= walk_last ? '0 : walk_addr + 1'b1;
      end
      if (state == S_IDLE && in_take && mode == MODE_REPORT) begin
        out_left <= k_eff;
      end else if (out_valid && !out_stall) begin
        out_left <= out_left - 1'b1;
      end
    end
  end

  // Count memory: one write and one read port.
  assign mem_we  = (state == S_WIPE) || (state == S_ADD_WR);
  assign wr_addr = (state == S_WIPE) ? walk_addr : bin_addr;
  assign wr_data = (state == S_WIPE) ? '0 :
                   (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
  assign rd_addr = (state == S_ADD_RD) ? bin_addr : walk_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    ctrl.clear  = 1'b0;
    ctrl.insert = pipe_valid;
    ctrl.shift  = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (mode == MODE_ADD) begin
            state_next = S_ADD_MUL;
          end else if (mode == MODE_REPORT) begin
            ctrl.clear = 1'b1;
            state_next = S_REP_SCAN;
          end else if (mode == MODE_CLEAR) begin
            state_next = S_WIPE;
          end
        end
      end
      S_ADD_MUL: begin
        state_next = bin_ok ? S_ADD_RD : S_IDLE;
      end
      S_ADD_RD: begin
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        state_next = S_IDLE;
      end
      S_REP_SCAN: begin
        if (walk_last) begin
          state_next = S_REP_DRAIN;
        end
      end
      S_REP_DRAIN: begin
        state_next = S_REP_OUT;
      end
      S_REP_OUT: begin
        if (!out_stall) begin
          ctrl.shift = 1'b1;
          if (out_left == 7'd1) begin
            state_next = S_IDLE;
          end
        end
      end
      S_WIPE: begin
        if (walk_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  tbh_chain #(
    .N_CELLS(MAX_K),
    .IDX_W  (IDX_W)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .new_idx (pipe_idx),
    .new_cnt (rd_data),
    .head_idx(head_idx),
    .head_cnt(hit_count)
  );

  assign out_valid = (state == S_REP_OUT);
  assign bin_index = OUT_IDX_W'(head_idx);
  assign last      = (out_left == 7'd1);

  a_report_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && mode == MODE_REPORT)
      |=> (state == S_REP_SCAN && walk_addr == '0))
    else $error("report did not start its walk at bin zero");

  a_out_left_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_REP_OUT) |-> (out_left != '0 && out_left <= K_W'(K_CAP)))
    else $error("result counter out of range during output");

  a_last_ends_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (state == S_IDLE))
    else $error("report kept going after its last result");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_WR) |-> ($past(state) == S_ADD_RD))
    else $error("count write without a preceding read");

endmodule

>>> tb/time_bin_histogram_top_k_tb.sv
module time_bin_histogram_top_k_tb;
  import tbh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BINS = 16384;
  localparam int MAX_K = 64;
  localparam int unsigned HOUR_UNITS = 36;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [STAMP_W-1:0] BASE_HIGH = 27'd99999999;
  localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = {STAMP_W{1'b1}};
  localparam logic [STAMP_W-1:0] TOP_K_FIELD = 27'h7F;
  localparam int HOT_COUNT = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [STAMP_W-1:0] stamp;
  } job_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic [COUNT_W-1:0]   cnt;
    logic                 fin;
  } hit_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           mode = MODE_ADD;
  logic [STAMP_W-1:0]   stamp = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_IDX_W-1:0] bin_index;
  logic [COUNT_W-1:0]   hit_count;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = REG_BASE_TIME;
  logic [STAMP_W-1:0]   cfg_data = '0;

  // Expected-behavior state.
  logic [COUNT_W-1:0] bin_counts [NUM_BINS];
  logic [STAMP_W-1:0] base_now;
  logic [K_W-1:0]     top_k_now;
  hit_t               hits_due [$];

  job_t        stamp_jobs [$];
  job_t        next_job;
  hit_t        want;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned reports_seen = 0;
  int unsigned clears_seen = 0;
  int unsigned hits_checked = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 85;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned reports_left = 10;
  int unsigned clears_left = 4;
  int unsigned hot_bins [HOT_COUNT];

  time_bin_histogram_top_k #(
    .NUM_BINS(NUM_BINS),
    .MAX_K(MAX_K)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .stamp(stamp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bin_index(bin_index),
    .hit_count(hit_count),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               hits_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Scans the bins from the highest index down, so a bin only passes an entry
  // already in the row when its count is strictly larger; that gives the
  // larger index precedence among equal counts.
  function automatic void rank_top_bins();
    logic [OUT_IDX_W-1:0] idx_row [MAX_K];
    logic [COUNT_W-1:0]   cnt_row [MAX_K];
    int unsigned k;
    int unsigned filled;
    int unsigned p;
    int unsigned j;
    hit_t h;
    k = (top_k_now == 0) ? 1 : top_k_now;
    if (k > MAX_K) k = MAX_K;
    if (k > NUM_BINS) k = NUM_BINS;
    filled = 0;
    for (int b = NUM_BINS - 1; b >= 0; b--) begin
      p = filled;
      while (p > 0 && bin_counts[b] > cnt_row[p-1]) p--;
      if (p < k) begin
        j = (filled < k) ? filled : k - 1;
        while (j > p) begin
          idx_row[j] = idx_row[j-1];
          cnt_row[j] = cnt_row[j-1];
          j--;
        end
        idx_row[p] = OUT_IDX_W'(b);
        cnt_row[p] = bin_counts[b];
        if (filled < k) filled++;
      end
    end
    for (int i = 0; i < filled; i++) begin
      h.idx = idx_row[i];
      h.cnt = cnt_row[i];
      h.fin = (i == filled - 1);
      hits_due.push_back(h);
    end
  endfunction

  function automatic void tally_item(logic [1:0] md, logic [STAMP_W-1:0] st);
    int unsigned bin;
    case (md)
      MODE_ADD: begin
        if (st >= base_now) begin
          bin = (st - base_now) / HOUR_UNITS;
          if (bin < NUM_BINS && bin_counts[bin] != COUNT_MAX) bin_counts[bin]++;
        end
      end
      MODE_REPORT: begin
        reports_seen++;
        rank_top_bins();
      end
      MODE_CLEAR: begin
        clears_seen++;
        foreach (bin_counts[i]) bin_counts[i] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= 40) $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  // Driver: a new transaction is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tally_item(mode, stamp);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (stamp_jobs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_job = stamp_jobs.pop_front();
          in_valid <= 1'b1;
          mode <= next_job.mode;
          stamp <= next_job.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        hits_checked++;
        if (hits_due.size() == 0) begin
          flag_mismatch($sformatf("result bin %0d count %0d with nothing expected",
                                  bin_index, hit_count));
        end else begin
          want = hits_due.pop_front();
          if (bin_index !== want.idx)
            flag_mismatch($sformatf("bin_index %0d, expected %0d", bin_index, want.idx));
          if (hit_count !== want.cnt)
            flag_mismatch($sformatf("hit_count %0d for bin %0d, expected %0d",
                                    hit_count, want.idx, want.cnt));
          if (last !== want.fin)
            flag_mismatch($sformatf("last %b for bin %0d, expected %b",
                                    last, want.idx, want.fin));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (holds_done < hold_requests && out_valid) begin
        hold_left <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic queue_item(logic [1:0] md, logic [STAMP_W-1:0] st);
    job_t job;
    job.mode = md;
    job.stamp = st;
    stamp_jobs.push_back(job);
    queued_cnt++;
  endtask

  task automatic queue_bin(int unsigned bin, int unsigned offset);
    queue_item(MODE_ADD, base_now + STAMP_W'(HOUR_UNITS * bin + offset));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (accepted_cnt != queued_cnt || hits_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [STAMP_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE_TIME) base_now = val;
    else top_k_now = val[K_W-1:0];
  endtask

  // Mostly adds into a few hot bins so counts differ and tie, mixed with
  // reports, clears, unused codes and stamps that fall outside the histogram.
  task automatic random_phase(int unsigned n_items);
    int unsigned done_cnt;
    int unsigned roll;
    logic [STAMP_W-1:0] st;
    done_cnt = 0;
    hot_bins[0] = 0;
    hot_bins[1] = NUM_BINS - 1;
    for (int i = 2; i < HOT_COUNT; i++) hot_bins[i] = $urandom_range(0, NUM_BINS - 1);
    while (done_cnt < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 3 && reports_left > 0) begin
        reports_left--;
        queue_item(MODE_REPORT, STAMP_W'($urandom));
      end else if (roll >= 3 && roll < 5 && clears_left > 0) begin
        clears_left--;
        queue_item(MODE_CLEAR, STAMP_W'($urandom));
      end else if (roll < 8) begin
        queue_item(MODE_UNUSED, STAMP_W'($urandom));
      end else if (roll < 14) begin
        if (base_now > 0 && $urandom_range(0, 1) == 0)
          st = base_now - STAMP_W'($urandom_range(1, (base_now < 5000) ? base_now : 5000));
        else
          st = base_now + STAMP_W'(HOUR_UNITS * NUM_BINS + $urandom_range(0, 5000));
        queue_item(MODE_ADD, st);
      end else if (roll < 20) begin
        st = STAMP_W'($urandom);
        queue_item(MODE_ADD, st);
      end else begin
        queue_bin(hot_bins[$urandom_range(0, $urandom_range(0, HOT_COUNT - 1))],
                  $urandom_range(0, HOUR_UNITS - 1));
      end
      done_cnt++;
    end
    queue_item(MODE_REPORT, STAMP_W'($urandom));
  endtask

  initial begin
    foreach (bin_counts[i]) bin_counts[i] = '0;
    base_now = BASE_TIME_RESET;
    top_k_now = TOP_K_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Bin edges, dropped stamps and the unused code under the reset settings.
    queue_item(MODE_ADD, base_now);
    queue_item(MODE_ADD, base_now - 1);
    queue_bin(0, HOUR_UNITS - 1);
    queue_bin(1, 0);
    queue_bin(NUM_BINS - 1, 0);
    queue_bin(NUM_BINS - 1, HOUR_UNITS - 1);
    queue_bin(NUM_BINS, 0);
    queue_item(MODE_ADD, '0);
    queue_item(MODE_ADD, STAMP_ALL_ONES);
    queue_item(MODE_UNUSED, STAMP_ALL_ONES);
    queue_item(MODE_UNUSED, '0);
    queue_item(MODE_REPORT, '0);
    queue_item(MODE_CLEAR, STAMP_ALL_ONES);
    // An empty histogram still reports its highest-index bins.
    queue_item(MODE_REPORT, STAMP_ALL_ONES);
    repeat (3) queue_bin(5, $urandom_range(0, HOUR_UNITS - 1));
    repeat (2) queue_bin(7, $urandom_range(0, HOUR_UNITS - 1));
    repeat (2) queue_bin(9, $urandom_range(0, HOUR_UNITS - 1));
    queue_item(MODE_REPORT, '0);
    random_phase(100);
    wait_drained();

    // Zero top_k acts as one; the upper data bits must be ignored.
    write_reg(REG_BASE_TIME, '0);
    write_reg(REG_TOP_K, STAMP_W'($urandom) & ~TOP_K_FIELD);
    hold_requests = 1;
    random_phase(90);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 25;
    write_reg(REG_BASE_TIME, BASE_HIGH);
    write_reg(REG_TOP_K, STAMP_W'(MAX_K));
    random_phase(90);
    wait_drained();

    write_reg(REG_BASE_TIME, STAMP_W'($urandom_range(1, BASE_HIGH)));
    write_reg(REG_TOP_K, STAMP_W'($urandom) | TOP_K_FIELD);
    random_phase(90);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BASE_TIME, BASE_TIME_RESET);
    write_reg(REG_TOP_K, STAMP_W'($urandom_range(1, MAX_K)));
    random_phase(90);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d reports, %0d clears, %0d results checked.",
             accepted_cnt, reports_seen, clears_seen, hits_checked);
    $display("Five register settings, top_k from zero to 127, %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
